@@ design/tdcp_pkg.sv @@
package tdcp_pkg;

  // Command bytes
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  localparam int unsigned DEC_BASE = 10;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [3:0] {
    CLS_U,
    CLS_J,
    CLS_B,
    CLS_L,
    CLS_F,
    CLS_S,
    CLS_SEMI,
    CLS_DIGIT,
    CLS_BLANK,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

@@ design/tdcp_if.sv @@
interface tdcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface tdcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;
  logic [1:0] color;

  modport source (output valid, output char_code, output col, output row, output color,
                  input ready);
  modport sink (input valid, input char_code, input col, input row, input color,
                output ready);
endinterface

@@ design/tdcp_front.sv @@
module tdcp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tdcp_in_if.sink               in_i,
  input  logic                  pop_i,
  output tdcp_pkg::queue_head_t head_o
);
  import tdcp_pkg::*;

  cmd_t              cmd_w;
  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  // Classify the incoming byte
  always_comb begin
    cmd_w.data = in_i.byte_in;
    case (in_i.byte_in)
      CH_U:    cmd_w.cls = CLS_U;
      CH_J:    cmd_w.cls = CLS_J;
      CH_B:    cmd_w.cls = CLS_B;
      CH_L:    cmd_w.cls = CLS_L;
      CH_F:    cmd_w.cls = CLS_F;
      CH_S:    cmd_w.cls = CLS_S;
      CH_SEMI: cmd_w.cls = CLS_SEMI;
      default: begin
        if (in_i.byte_in inside {[CH_ZERO:CH_NINE]}) begin
          cmd_w.cls = CLS_DIGIT;
        end else if (in_i.byte_in inside {CH_SPACE, CH_TAB}) begin
          cmd_w.cls = CLS_BLANK;
        end else begin
          cmd_w.cls = CLS_OTHER;
        end
      end
    endcase
  end

  assign in_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_w;
    end
  end

endmodule

@@ design/tdcp_back.sv @@
module tdcp_back #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdcp_pkg::queue_head_t head_i,
  output logic                  pop_o,
  tdcp_out_if.source            out_o
);
  import tdcp_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_GX    = 2'd1;
  localparam logic [1:0] MODE_GY    = 2'd2;
  localparam logic [1:0] MODE_COLOR = 2'd3;

  localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

  typedef logic [COORD_BITS-1:0] coord_t;

  function automatic coord_t inc_sat(input coord_t v);
    return (v == CMAX) ? v : v + 1'b1;
  endfunction

  function automatic coord_t dec_sat(input coord_t v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // v*10 + digit, saturated
  function automatic coord_t acc_digit(input coord_t v, input logic [3:0] d);
    logic [COORD_BITS+3:0] s;
    s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{COORD_BITS{1'b0}}, d};
    return (s > {4'b0000, CMAX}) ? CMAX : s[COORD_BITS-1:0];
  endfunction

  logic [1:0] mode_q, mode_d;
  coord_t     ccol_q, ccol_d;
  coord_t     crow_q, crow_d;
  coord_t     pcol_q, pcol_d;
  coord_t     prow_q, prow_d;
  logic [1:0] color_q, color_d;

  logic       emits;
  logic       take;
  logic       out_free;
  logic       out_valid_q;
  logic [7:0] char_q;
  logic [7:0] col_q;
  logic [7:0] row_q;
  logic [1:0] ocolor_q;

  logic [COORD_BITS+7:0] ccol_ext;
  logic [COORD_BITS+7:0] crow_ext;

  cls_e       cls;
  logic [7:0] data;

  assign cls  = head_i.cmd.cls;
  assign data = head_i.cmd.data;

  always_comb begin
    mode_d  = mode_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    pcol_d  = pcol_q;
    prow_d  = prow_q;
    color_d = color_q;
    emits   = 1'b0;
    case (mode_q)
      MODE_IDLE: begin
        case (cls)
          CLS_U: begin
            mode_d = MODE_GX;
            pcol_d = '0;
          end
          CLS_J:   ccol_d = inc_sat(ccol_q);
          CLS_B:   ccol_d = dec_sat(ccol_q);
          CLS_L:   crow_d = inc_sat(crow_q);
          CLS_F:   crow_d = dec_sat(crow_q);
          CLS_S:   mode_d = MODE_COLOR;
          default: emits = 1'b1;
        endcase
      end
      MODE_GX: begin
        case (cls)
          CLS_SEMI: begin
            mode_d = MODE_GY;
            prow_d = '0;
          end
          CLS_DIGIT: pcol_d = acc_digit(pcol_q, data[3:0]);
          CLS_BLANK: ;
          default:   mode_d = MODE_IDLE;
        endcase
      end
      MODE_GY: begin
        case (cls)
          CLS_DIGIT: prow_d = acc_digit(prow_q, data[3:0]);
          CLS_BLANK: ;
          default: begin
            mode_d = MODE_IDLE;
            ccol_d = pcol_q;
            crow_d = prow_q;
          end
        endcase
      end
      default: begin
        // color digit '0' to '3'
        if (cls == CLS_DIGIT && data[3:2] == 2'b00) begin
          color_d = data[1:0];
        end
        mode_d = MODE_IDLE;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign take     = head_i.valid && (!emits || out_free);
  assign pop_o    = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ccol_q  <= '0;
      crow_q  <= '0;
      pcol_q  <= '0;
      prow_q  <= '0;
      color_q <= '0;
    end else if (take) begin
      mode_q  <= mode_d;
      ccol_q  <= ccol_d;
      crow_q  <= crow_d;
      pcol_q  <= pcol_d;
      prow_q  <= prow_d;
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emits) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign ccol_ext = {8'h00, ccol_q};
  assign crow_ext = {8'h00, crow_q};

  always_ff @(posedge clk_i) begin
    if (take && emits) begin
      char_q   <= data;
      col_q    <= ccol_ext[7:0];
      row_q    <= crow_ext[7:0];
      ocolor_q <= color_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.col       = col_q;
  assign out_o.row       = row_q;
  assign out_o.color     = ocolor_q;

endmodule

@@ design/text_display_command_parser_core.sv @@
// Path: an accepted byte is written into the command queue; the back end takes it
// from the queue head and registers its character result in the output register.
// Throughput: one byte per cycle while out_o.ready stays high; the two-entry command
// queue and the output register absorb stalls until both are full.
// Reset (rst_ni low, asynchronous): idle mode, cursor, goto coordinates and
// color cleared to zero, queue emptied, no result pending.
module text_display_command_parser_core #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdcp_in_if.sink     in_i,
  tdcp_out_if.source  out_o
);
  import tdcp_pkg::*;

  queue_head_t head;
  logic        pop;

  tdcp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  tdcp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  // Pop only from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid)
    else $error("pop from empty command queue");

  // A new result appears only after a command was popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(pop))
    else $error("result without a popped command");

  // Queue fills up only through an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_i.ready) |-> $past(in_i.valid))
    else $error("queue became full without a request");

endmodule

@@ tb/sv/tb_text_display_command_parser_core.sv @@
`timescale 1ns / 1ps

module tb_text_display_command_parser_core;
  import tdcp_pkg::*;

  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned ITEMS      = 2000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    PM_IDLE,
    PM_GOTO_X,
    PM_GOTO_Y,
    PM_COLOR
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] color;
  } draw_t;

  class draw_scoreboard;
    parse_mode_e mode;
    coord_t      cur_col;
    coord_t      cur_row;
    coord_t      goto_col;
    coord_t      goto_row;
    logic [1:0]  pen;
    draw_t       draws[$];
    int unsigned errors;

    function new();
      mode     = PM_IDLE;
      cur_col  = '0;
      cur_row  = '0;
      goto_col = '0;
      goto_row = '0;
      pen      = '0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return draws.size();
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
    endfunction

    function coord_t step_up(coord_t v);
      return (v == coord_t'(COORD_MAX)) ? v : v + 1'b1;
    endfunction

    function coord_t step_down(coord_t v);
      return (v == '0) ? v : v - 1'b1;
    endfunction

    function coord_t add_digit(coord_t v, logic [7:0] b);
      int unsigned r;
      r = int'(v) * DEC_BASE + int'(b - CH_ZERO);
      return (r > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(r);
    endfunction

    // Advance the parser by one accepted request and queue any draw it causes.
    function void note_byte(logic [7:0] b);
      draw_t d;
      case (mode)
        PM_IDLE: begin
          if (b == CH_U) begin
            mode     = PM_GOTO_X;
            goto_col = '0;
          end else if (b == CH_J) begin
            cur_col = step_up(cur_col);
          end else if (b == CH_B) begin
            cur_col = step_down(cur_col);
          end else if (b == CH_L) begin
            cur_row = step_up(cur_row);
          end else if (b == CH_F) begin
            cur_row = step_down(cur_row);
          end else if (b == CH_S) begin
            mode = PM_COLOR;
          end else begin
            d.char_code = b;
            d.col       = 8'(cur_col);
            d.row       = 8'(cur_row);
            d.color     = pen;
            draws.push_back(d);
          end
        end
        PM_GOTO_X: begin
          if (b == CH_SEMI) begin
            mode     = PM_GOTO_Y;
            goto_row = '0;
          end else if (is_digit(b)) begin
            goto_col = add_digit(goto_col, b);
          end else if (!is_blank(b)) begin
            mode = PM_IDLE;
          end
        end
        PM_GOTO_Y: begin
          if (is_digit(b)) begin
            goto_row = add_digit(goto_row, b);
          end else if (!is_blank(b)) begin
            mode    = PM_IDLE;
            cur_col = goto_col;
            cur_row = goto_row;
          end
        end
        default: begin
          if (b >= CH_ZERO && b <= CH_ZERO + 8'd3) pen = 2'(b - CH_ZERO);
          mode = PM_IDLE;
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_draw(draw_t got);
      draw_t want;
      if (draws.size() == 0) begin
        report($sformatf("unexpected draw char %02h at (%0d,%0d) color %0d",
                         got.char_code, got.col, got.row, got.color));
        return;
      end
      want = draws.pop_front();
      if (got.char_code !== want.char_code)
        report($sformatf("char_code %02h, want %02h", got.char_code, want.char_code));
      if (got.col !== want.col)
        report($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.row !== want.row)
        report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.color !== want.color)
        report($sformatf("color %0d, want %0d", got.color, want.color));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  tdcp_in_if  in_if ();
  tdcp_out_if out_if ();

  text_display_command_parser_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  draw_scoreboard sb = new();

  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_req_cnt;
  int unsigned sent_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_byte(in_if.byte_in);
  end

  always @(posedge clk_i) begin
    draw_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.char_code = out_if.char_code;
      got.col       = out_if.col;
      got.row       = out_if.row;
      got.color     = out_if.color;
      sb.check_draw(got);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("** text_display_command_parser_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
  endtask

  // Drop valid and hold until every queued draw has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_number(ref logic [7:0] q[$], input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(9) == 0) q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      q.push_back(8'(s[i]));
    end
  endfunction

  function automatic int unsigned rand_coord();
    return ($urandom_range(3) == 0) ? $urandom_range(99999) : $urandom_range(300);
  endfunction

  function automatic logic [7:0] rand_goto_end(bit in_y);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_TAB ||
           (!in_y && b == CH_SEMI));
    return b;
  endfunction

  task automatic send_random_sequence();
    logic [7:0]  q[$];
    logic [7:0]  moves[4];
    int unsigned kind;
    kind  = $urandom_range(99);
    moves = '{CH_J, CH_B, CH_L, CH_F};
    if (kind < 35) begin
      repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255)));
    end else if (kind < 55) begin
      repeat ($urandom_range(5, 1)) q.push_back(moves[$urandom_range(3)]);
    end else if (kind < 80) begin
      q.push_back(CH_U);
      if ($urandom_range(9) == 0) q.push_back(CH_SPACE);
      if ($urandom_range(9) != 0) push_number(q, rand_coord());
      if ($urandom_range(7) == 0) begin
        q.push_back(rand_goto_end(1'b0));
      end else begin
        q.push_back(CH_SEMI);
        if ($urandom_range(9) == 0) q.push_back(CH_TAB);
        if ($urandom_range(9) != 0) push_number(q, rand_coord());
        q.push_back(($urandom_range(5) == 0) ? CH_SEMI : rand_goto_end(1'b1));
      end
    end else if (kind < 90) begin
      q.push_back(CH_S);
      q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : CH_ZERO + 8'($urandom_range(3)));
    end else begin
      q.push_back(8'($urandom_range(255)));
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  initial begin
    logic [7:0] dir_bytes[$];
    dir_bytes = '{
      CH_B, CH_F, 8'h00,
      // goto beyond the maximum in both fields, with blanks, ended by ';'
      CH_U, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_SPACE, CH_ZERO + 8'd9, CH_SEMI,
      CH_TAB, CH_ZERO + 8'd7, CH_ZERO, CH_ZERO, CH_SEMI,
      CH_J, CH_L, 8'hFF,
      CH_S, CH_ZERO + 8'd3, CH_S, 8'h5A,
      // goto abandoned in the x field leaves the cursor alone
      CH_U, CH_ZERO + 8'd4, 8'h51, 8'h7F
    };
    src_gap_pct    = 16;
    sink_stall_pct = 73;
    hold_req_cnt   = 0;
    sent_cnt       = 0;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.byte_in  <= 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
    while (sent_cnt < ITEMS / 3) send_random_sequence();
    drain();

    src_gap_pct    = 73;
    sink_stall_pct = 16;
    while (sent_cnt < 2 * ITEMS / 3) send_random_sequence();
    drain();

    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_req_cnt++;
    while (sent_cnt < ITEMS) send_random_sequence();
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** text_display_command_parser_core: PASSED **");
    end else begin
      $display("** text_display_command_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
